// ===== src/mwss_pkg.sv =====
// Package for the masked word sequence scanner: request and result structs,
// action codes, register indexes and parameter defaults. No dependencies.
`default_nettype none

package mwss_pkg;

  localparam int unsigned PATTERN_DEPTH_DEF = 16;
  localparam int unsigned RESULT_LIMIT_DEF  = 16;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 5;

  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LENGTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_MATCHES    = 2'd1;

  localparam logic [CFG_DATA_W-1:0] PATTERN_LENGTH_RST = 5'd1;
  localparam logic [CFG_DATA_W-1:0] MAX_MATCHES_RST    = 5'd16;

  typedef enum logic [1:0] {
    ACT_LOAD    = 2'd0,
    ACT_RESTART = 2'd1,
    ACT_SCAN    = 2'd2
  } action_e;

  typedef struct packed {
    action_e     action;
    logic [3:0]  entry_index;
    logic [31:0] entry_mask;
    logic [31:0] entry_value;
    logic [31:0] word;
  } in_t;

  typedef struct packed {
    logic [31:0] match_offset;
    logic [4:0]  match_number;
    logic        limit_reached;
  } out_t;

endpackage

`default_nettype wire

// ===== src/masked_word_sequence_scanner_unit.sv =====
// Top level of the masked word sequence scanner: request stage, pattern RAM,
// compare stage and result register. Depends on mwss_pkg and mwss_ram.
//
// One request is taken every cycle unless the compare stage stalls, and a match
// result is loaded into the result register as the word that completes it
// leaves the compare stage. Load requests write the pattern RAM as they are
// taken; scan requests read the entry at the current progress, and the address
// for the next word comes straight from the compare of the word in the compare
// stage. A result waiting in the output register stalls the compare stage
// only when that stage holds another completed match. There is no clearing
// pass: pattern entries must be loaded before they are scanned against.
`default_nettype none

module masked_word_sequence_scanner_unit #(
  parameter int unsigned PATTERN_DEPTH = mwss_pkg::PATTERN_DEPTH_DEF,
  parameter int unsigned RESULT_LIMIT  = mwss_pkg::RESULT_LIMIT_DEF
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [mwss_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [mwss_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  wire logic                            in_valid_i,
  output logic                                 in_ready_o,
  input  wire mwss_pkg::in_t                   in_data_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_ready_i,
  output mwss_pkg::out_t                       out_data_o
);

  import mwss_pkg::*;

  localparam int unsigned AW = (PATTERN_DEPTH > 1) ? $clog2(PATTERN_DEPTH) : 1;
  localparam int unsigned PW = $clog2(PATTERN_DEPTH + 1);
  localparam int unsigned MW = $clog2(RESULT_LIMIT + 1);

  logic [CFG_DATA_W-1:0] pattern_length_q, max_matches_q;

  logic          s1_valid_q, s1_valid_d;
  action_e       s1_action_q;
  logic [31:0]   s1_word_q;

  logic [PW-1:0] progress_q, progress_d;
  logic [31:0]   pos_q, pos_d;
  logic [MW-1:0] matches_q, matches_d;
  logic          stopped_q, stopped_d;

  logic          out_valid_q, out_valid_d;
  out_t          out_q, out_d;

  logic [63:0]   rd_data;
  logic [PW-1:0] len, run;
  logic [MW-1:0] lim, matches_inc;
  logic [31:0]   pos_inc;
  logic          hit, complete, s1_res, s1_adv, s1_fire;
  logic          in_acc, ram_we, ram_re;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pattern_length_q <= PATTERN_LENGTH_RST;
      max_matches_q    <= MAX_MATCHES_RST;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CFG_PATTERN_LENGTH) begin
        pattern_length_q <= cfg_data_i;
      end else if (cfg_idx_i == CFG_MAX_MATCHES) begin
        max_matches_q <= cfg_data_i;
      end
    end
  end

  // clamp length and limit into range
  always_comb begin
    if (pattern_length_q == '0) begin
      len = PW'(1);
    end else if (32'(pattern_length_q) > 32'(PATTERN_DEPTH)) begin
      len = PW'(PATTERN_DEPTH);
    end else begin
      len = PW'(pattern_length_q);
    end
    if (max_matches_q == '0) begin
      lim = MW'(1);
    end else if (32'(max_matches_q) > 32'(RESULT_LIMIT)) begin
      lim = MW'(RESULT_LIMIT);
    end else begin
      lim = MW'(max_matches_q);
    end
  end

  // compare stage decode
  assign hit         = (s1_word_q & rd_data[63:32]) == rd_data[31:0];
  assign run         = progress_q + PW'(1);
  assign complete    = hit && (run >= len);
  assign matches_inc = matches_q + MW'(1);
  assign pos_inc     = pos_q + 32'd4;
  assign s1_res      = s1_valid_q && (s1_action_q == ACT_SCAN) && !stopped_q && complete;
  assign s1_adv      = !s1_res || !out_valid_q || out_ready_i;
  assign s1_fire     = s1_valid_q && s1_adv;

  assign in_ready_o  = !s1_valid_q || s1_adv;
  assign in_acc      = in_valid_i && in_ready_o;

  // scan state update
  always_comb begin
    progress_d = progress_q;
    pos_d      = pos_q;
    matches_d  = matches_q;
    stopped_d  = stopped_q;
    if (s1_fire) begin
      unique case (s1_action_q)
        ACT_RESTART: begin
          progress_d = '0;
          pos_d      = '0;
          matches_d  = '0;
          stopped_d  = 1'b0;
        end
        ACT_SCAN: begin
          if (!stopped_q) begin
            pos_d = pos_inc;
            if (!hit) begin
              progress_d = '0;
            end else if (!complete) begin
              progress_d = run;
            end else begin
              progress_d = '0;
              matches_d  = matches_inc;
              stopped_d  = matches_inc >= lim;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // result register
  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (s1_fire && s1_res) begin
      out_valid_d         = 1'b1;
      out_d.match_offset  = pos_inc - (32'(run) << 2);
      out_d.match_number  = 5'(matches_inc);
      out_d.limit_reached = matches_inc >= lim;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_acc) begin
      s1_valid_d = 1'b1;
    end else if (s1_adv) begin
      s1_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      progress_q  <= '0;
      pos_q       <= '0;
      matches_q   <= '0;
      stopped_q   <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      progress_q  <= progress_d;
      pos_q       <= pos_d;
      matches_q   <= matches_d;
      stopped_q   <= stopped_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
    if (in_acc) begin
      s1_action_q <= in_data_i.action;
      s1_word_q   <= in_data_i.word;
    end
  end

  // pattern store, read address forwarded from the compare stage
  assign ram_we = in_acc && (in_data_i.action == ACT_LOAD)
                  && (32'(in_data_i.entry_index) < 32'(PATTERN_DEPTH));
  assign ram_re = in_acc && (in_data_i.action == ACT_SCAN);

  mwss_ram #(
    .WIDTH (64),
    .DEPTH (PATTERN_DEPTH)
  ) u_pattern_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (AW'(in_data_i.entry_index)),
    .wdata_i ({in_data_i.entry_mask, in_data_i.entry_value}),
    .re_i    (ram_re),
    .raddr_i (progress_d[AW-1:0]),
    .rdata_o (rd_data)
  );

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_progress_in_store: assert property (@(posedge clk_i) disable iff (!rst_ni)
    progress_q < PW'(PATTERN_DEPTH))
    else $error("match progress points past the pattern store");

  a_count_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    matches_q <= MW'(RESULT_LIMIT))
    else $error("match count exceeds the result limit");

  a_stop_needs_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stopped_q |-> (matches_q != '0))
    else $error("scan stopped without any match");

  a_result_loaded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_fire && s1_res) |=> out_valid_q)
    else $error("completed match did not reach the result register");

endmodule

`default_nettype wire

// ===== src/mwss_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
// Standalone, no package dependency.
`default_nettype none

module mwss_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ===== tb/sv/masked_word_sequence_scanner_unit_tb.sv =====
// Self-checking testbench for masked_word_sequence_scanner_unit: directed corner tests,
// random scan phases and an output stall, all checked against an in-bench scanner model.
// Depends on mwss_pkg and the scanner RTL only.
module masked_word_sequence_scanner_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mwss_pkg::*;

  localparam int unsigned DEPTH       = PATTERN_DEPTH_DEF;
  localparam int unsigned LIMIT       = RESULT_LIMIT_DEF;
  localparam int          ITEM_TARGET = 1600;
  localparam action_e     ACT_UNUSED  = action_e'(2'd3);

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;
  logic                  in_valid_i;
  logic                  in_ready_o;
  in_t                   in_data_i;
  logic                  out_valid_o;
  logic                  out_ready_i;
  out_t                  out_data_o;

  masked_word_sequence_scanner_unit uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  always #5 clk_i = ~clk_i;

  // scanner model state
  logic [31:0] pat_mask  [DEPTH];
  logic [31:0] pat_value [DEPTH];
  logic [4:0]  prog;
  logic [4:0]  hits;
  logic [4:0]  cfg_len;
  logic [4:0]  cfg_lim;
  logic [31:0] pos;
  logic        halted;
  out_t        expected_matches [$];

  // stimulus side copy of the pattern
  logic [31:0] gen_mask  [DEPTH];
  logic [31:0] gen_value [DEPTH];
  int unsigned gen_len;

  int errors;
  int item_count;
  int hold_cycles;
  bit steady;

  function automatic int unsigned bounded(logic [4:0] v, int unsigned hi);
    if (v == 5'd0) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  task automatic advance_scanner(in_t req);
    int unsigned len;
    int unsigned lim;
    int unsigned p;
    int unsigned run;
    out_t res;
    case (req.action)
      ACT_LOAD: begin
        pat_mask[req.entry_index]  = req.entry_mask;
        pat_value[req.entry_index] = req.entry_value;
      end
      ACT_RESTART: begin
        prog   = '0;
        pos    = '0;
        hits   = '0;
        halted = 1'b0;
      end
      ACT_SCAN: begin
        if (!halted) begin
          len = bounded(cfg_len, DEPTH);
          lim = bounded(cfg_lim, LIMIT);
          p = prog;
          if (p >= DEPTH) p = 0;
          pos = pos + 32'd4;
          if ((req.word & pat_mask[p]) != pat_value[p]) begin
            prog = '0;
          end else begin
            run = p + 1;
            if (run < len) begin
              prog = 5'(run);
            end else begin
              prog = '0;
              hits = hits + 5'd1;
              if (hits >= lim) halted = 1'b1;
              res.match_offset  = pos - 32'(run * 4);
              res.match_number  = hits;
              res.limit_reached = halted;
              expected_matches.push_back(res);
            end
          end
        end
      end
      default: ;
    endcase
  endtask

  always @(posedge clk_i) begin : monitor
    out_t want;
    if (rst_ni) begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_PATTERN_LENGTH: cfg_len = cfg_data_i;
          CFG_MAX_MATCHES:    cfg_lim = cfg_data_i;
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_o) advance_scanner(in_data_i);
      if (out_valid_o && out_ready_i) begin
        if (expected_matches.size() == 0) begin
          errors++;
          $error("unexpected result: offset %0h number %0d limit %0b",
                 out_data_o.match_offset, out_data_o.match_number, out_data_o.limit_reached);
        end else begin
          want = expected_matches.pop_front();
          if (out_data_o.match_offset !== want.match_offset) begin
            errors++;
            $error("match_offset: expected %0h, actual %0h",
                   want.match_offset, out_data_o.match_offset);
          end
          if (out_data_o.match_number !== want.match_number) begin
            errors++;
            $error("match_number: expected %0d, actual %0d",
                   want.match_number, out_data_o.match_number);
          end
          if (out_data_o.limit_reached !== want.limit_reached) begin
            errors++;
            $error("limit_reached: expected %0b, actual %0b",
                   want.limit_reached, out_data_o.limit_reached);
          end
        end
      end
    end
  end

  // result side: random stalls, plus one long hold-off from the backpressure test
  initial begin : receiver
    int stall;
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      stall = steady ? 0 : $urandom_range(0, 4);
      if (hold_cycles > 0) begin
        stall = hold_cycles;
        hold_cycles = 0;
      end
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      out_ready_i <= 1'b1;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
      @(negedge clk_i);
    end
  end

  task automatic send_request(in_t req);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 4);
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_data_i  <= req;
    in_valid_i <= 1'b1;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    if (req.action != ACT_UNUSED) item_count++;
  endtask

  function automatic in_t random_request(action_e act);
    in_t r;
    r.action      = act;
    r.entry_index = 4'($urandom);
    r.entry_mask  = $urandom;
    r.entry_value = $urandom;
    r.word        = $urandom;
    return r;
  endfunction

  task automatic load_entry(int idx, logic [31:0] mask, logic [31:0] value);
    in_t r;
    r = random_request(ACT_LOAD);
    r.entry_index = 4'(idx);
    r.entry_mask  = mask;
    r.entry_value = value;
    gen_mask[idx]  = mask;
    gen_value[idx] = value;
    send_request(r);
  endtask

  task automatic scan_word(logic [31:0] w);
    in_t r;
    r = random_request(ACT_SCAN);
    r.word = w;
    send_request(r);
  endtask

  task automatic restart_scan();
    send_request(random_request(ACT_RESTART));
  endtask

  task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    if (idx == CFG_PATTERN_LENGTH) gen_len = bounded(value, DEPTH);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
  endtask

  task automatic wait_idle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (expected_matches.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic random_entry(output logic [31:0] mask, output logic [31:0] value);
    case ($urandom_range(0, 7))
      0:       mask = '0;
      1:       mask = '1;
      2, 3:    mask = $urandom & $urandom & $urandom;
      default: mask = $urandom;
    endcase
    value = $urandom & mask;
    // sometimes an entry that no word can hit
    if ($urandom_range(0, 15) == 0) value = $urandom;
  endtask

  task automatic scan_run();
    int break_at;
    logic [31:0] w;
    break_at = ($urandom_range(0, 4) == 0) ? $urandom_range(0, gen_len - 1) : -1;
    for (int k = 0; k < gen_len; k++) begin
      w = ($urandom & ~gen_mask[k]) | gen_value[k];
      if (k == break_at) w = $urandom;
      scan_word(w);
    end
  endtask

  task automatic test_pattern_load();
    load_entry(0, 32'hFFFF_FFFF, 32'h0000_0000);
    load_entry(1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    for (int i = 2; i < DEPTH - 1; i++) load_entry(i, 32'h0, 32'h0);
    load_entry(DEPTH - 1, 32'h0000_FFFF, 32'h0000_1234);
  endtask

  task automatic test_reset_settings();
    scan_word(32'hFFFF_FFFF);
    scan_word(32'h0000_0000);
    send_request(random_request(ACT_UNUSED));
    wait_idle();
  endtask

  task automatic test_stop_and_restart();
    write_register(CFG_PATTERN_LENGTH, 5'd3);
    write_register(CFG_MAX_MATCHES, 5'd1);
    scan_word(32'h0000_0000);
    scan_word(32'hFFFF_FFFF);
    scan_word(32'h0000_0000);
    // stopped: this word is dropped
    scan_word(32'h0000_0000);
    restart_scan();
    wait_idle();
  endtask

  task automatic test_lowered_settings();
    write_register(CFG_PATTERN_LENGTH, 5'd16);
    write_register(CFG_MAX_MATCHES, 5'd31);
    scan_word(32'h0000_0000);
    scan_word(32'hFFFF_FFFF);
    scan_word(32'h0000_0000);
    scan_word(32'h0000_0000);
    wait_idle();
    // length drops below the progress already made
    write_register(CFG_PATTERN_LENGTH, 5'd0);
    scan_word(32'h5A5A_5A5A);
    wait_idle();
    // limit drops to the match count already reached
    write_register(CFG_MAX_MATCHES, 5'd0);
    scan_word(32'h0000_0000);
    restart_scan();
    wait_idle();
  endtask

  task automatic test_random_phases();
    int phase;
    int goal;
    int r;
    logic [4:0] len;
    logic [4:0] lim;
    logic [31:0] mask;
    logic [31:0] value;
    phase = 0;
    while (item_count < ITEM_TARGET) begin
      case (phase)
        0: begin len = 5'd1;  lim = 5'd1;  end
        1: begin len = 5'd16; lim = 5'd16; end
        2: begin len = 5'd0;  lim = 5'd0;  end
        3: begin len = 5'd31; lim = 5'd31; end
        default: begin
          len = ($urandom_range(0, 7) == 0) ? 5'($urandom_range(0, 31)) : 5'($urandom_range(1, 6));
          lim = 5'($urandom_range(0, 31));
        end
      endcase
      steady = (phase % 6 == 5);
      write_register(CFG_PATTERN_LENGTH, len);
      write_register(CFG_MAX_MATCHES, lim);
      for (int i = 0; i < gen_len; i++) begin
        random_entry(mask, value);
        load_entry(i, mask, value);
      end
      if ($urandom_range(0, 1) == 0) restart_scan();
      goal = item_count + 100;
      while (item_count < goal) begin
        r = $urandom_range(0, 99);
        if (r < 65) begin
          scan_run();
        end else if (r < 78) begin
          scan_word($urandom);
        end else if (r < 84) begin
          restart_scan();
        end else if (r < 92) begin
          random_entry(mask, value);
          load_entry($urandom_range(0, DEPTH - 1), mask, value);
        end else if (r < 96) begin
          send_request(random_request(ACT_UNUSED));
        end else begin
          scan_word(($urandom_range(0, 1) == 0) ? 32'h0 : 32'hFFFF_FFFF);
        end
      end
      wait_idle();
      steady = 1'b0;
      phase++;
    end
  endtask

  task automatic test_backpressure();
    write_register(CFG_PATTERN_LENGTH, 5'd1);
    write_register(CFG_MAX_MATCHES, 5'd16);
    load_entry(0, 32'h0, 32'h0);
    restart_scan();
    hold_cycles = 64;
    steady = 1'b1;
    for (int k = 0; k < 48; k++) begin
      if (k % 12 == 11) restart_scan();
      else scan_word($urandom);
    end
    wait_idle();
    steady = 1'b0;
  endtask

  initial begin
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = '0;
    cfg_data_i  = '0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    errors      = 0;
    item_count  = 0;
    hold_cycles = 0;
    steady      = 1'b0;
    prog        = '0;
    hits        = '0;
    pos         = '0;
    halted      = 1'b0;
    cfg_len     = PATTERN_LENGTH_RST;
    cfg_lim     = MAX_MATCHES_RST;
    gen_len     = bounded(PATTERN_LENGTH_RST, DEPTH);
    for (int i = 0; i < DEPTH; i++) begin
      pat_mask[i]  = '0;
      pat_value[i] = '0;
      gen_mask[i]  = '0;
      gen_value[i] = '0;
    end
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;

    test_pattern_load();
    test_reset_settings();
    test_stop_and_restart();
    test_lowered_settings();
    test_random_phases();
    test_backpressure();

    wait_idle();
    repeat (8) @(posedge clk_i);
    if (errors == 0 && expected_matches.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #(5_000_000);
    $display("Verification failed");
    $finish;
  end

endmodule
